// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent checks on clk_i, disabled while rst_ni is low. Both macros
// collapse to nothing when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check a property at every rising edge of clk_i
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that cons holds in the cycle after ante
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_PROP(label, prop, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/splcp_pkg.sv =====
// ---------------------------------------------------------------------------
// splcp_pkg
// Types and constants of the signed pair line command parser: grammar
// phases, character codes and the digit magnitude ceiling.
// ---------------------------------------------------------------------------
package splcp_pkg;

  // Position in the line grammar
  typedef logic [2:0] phase_t;

  localparam phase_t PH_R_START = 3'd0;
  localparam phase_t PH_R_WS    = 3'd1;
  localparam phase_t PH_R_SIGN  = 3'd2;
  localparam phase_t PH_R_DIG   = 3'd3;
  localparam phase_t PH_L_START = 3'd4;
  localparam phase_t PH_L_SIGN  = 3'd5;
  localparam phase_t PH_L_DIG   = 3'd6;
  localparam phase_t PH_L_TAIL  = 3'd7;

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Digit magnitude saturates here
  localparam logic [8:0] MAG_MAX = 9'd511;

  // Reset value of the clamp bound
  localparam logic [7:0] PWM_LIMIT_RST = 8'd255;

endpackage

// ===== rtl/signed_pair_line_command_parser.sv =====
// ---------------------------------------------------------------------------
// signed_pair_line_command_parser: parses "right/left" decimal pairs per line
// Path: a byte beat is registered in the input stage, then parsed into the
// result register; a line end loads it only with a valid, changed pair.
// Throughput: one byte per cycle while no result stall holds the input stage.
// Reset: parser, last sent pair and output valid clear; pwm limit returns to 255.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module signed_pair_line_command_parser #(
  parameter int LINE_BUFFER_SIZE = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_data_i,
  // byte input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        rx_byte_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic signed [8:0] right_drive_o,
  output logic signed [8:0] left_drive_o
);

  localparam int LenW = $clog2(LINE_BUFFER_SIZE);
  localparam logic [LenW-1:0] LenLast = LenW'(LINE_BUFFER_SIZE - 1);

  // Multiply by ten, add a digit, saturate
  function automatic logic [8:0] add_digit(input logic [8:0] mag, input logic [3:0] d);
    logic [12:0] v;
    v = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0} + {9'd0, d};
    return (v > {4'd0, splcp_pkg::MAG_MAX}) ? splcp_pkg::MAG_MAX : v[8:0];
  endfunction

  // Clamp a magnitude to the limit and apply the sign
  function automatic logic [8:0] clamp_pattern(input logic neg, input logic [8:0] mag,
                                               input logic [7:0] lim);
    logic [8:0] m;
    m = (mag > {1'b0, lim}) ? {1'b0, lim} : mag;
    return neg ? (~m + 9'd1) : m;
  endfunction

  // Configuration register
  logic [7:0] pwm_limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_limit_q <= splcp_pkg::PWM_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      pwm_limit_q <= cfg_data_i;
    end
  end

  // Input register stage
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_adv, s1_fire, in_fire;
  logic       out_valid_q, out_valid_d;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= rx_byte_i;
    end
  end

  // Parser state
  logic [LenW-1:0]   len_q, len_d;
  splcp_pkg::phase_t phase_q, phase_d;
  logic              invalid_q, invalid_d;
  logic              r_neg_q, r_neg_d, l_neg_q, l_neg_d;
  logic [8:0]        r_mag_q, r_mag_d, l_mag_q, l_mag_d;
  logic              last_valid_q, last_valid_d;
  logic [8:0]        last_r_q, last_r_d, last_l_q, last_l_d;

  // Classify the byte
  logic       is_eol, is_dig, is_ws, is_sgn, is_sl, is_collect, is_minus;
  logic [3:0] digit;
  logic [8:0] r_add, l_add;
  logic [8:0] r_pat, l_pat;
  logic       line_ok, emit;

  assign is_eol     = (s1_byte_q == splcp_pkg::CH_CR) || (s1_byte_q == splcp_pkg::CH_LF);
  assign is_dig     = (s1_byte_q >= splcp_pkg::CH_ZERO) && (s1_byte_q <= splcp_pkg::CH_NINE);
  assign is_ws      = (s1_byte_q == splcp_pkg::CH_SPACE) || (s1_byte_q == splcp_pkg::CH_TAB);
  assign is_minus   = (s1_byte_q == splcp_pkg::CH_MINUS);
  assign is_sgn     = is_minus || (s1_byte_q == splcp_pkg::CH_PLUS);
  assign is_sl      = (s1_byte_q == splcp_pkg::CH_SLASH);
  assign is_collect = is_dig || is_ws || is_sgn || is_sl;
  assign digit      = s1_byte_q[3:0];
  assign r_add      = add_digit(r_mag_q, digit);
  assign l_add      = add_digit(l_mag_q, digit);

  // Pair and its emission test at line end
  assign r_pat   = clamp_pattern(r_neg_q, r_mag_q, pwm_limit_q);
  assign l_pat   = clamp_pattern(l_neg_q, l_mag_q, pwm_limit_q);
  assign line_ok = (len_q != '0) && !invalid_q &&
                   ((phase_q == splcp_pkg::PH_L_START) || (phase_q == splcp_pkg::PH_L_DIG) ||
                    (phase_q == splcp_pkg::PH_L_TAIL));
  assign emit    = s1_fire && is_eol && line_ok &&
                   (!last_valid_q || (r_pat != last_r_q) || (l_pat != last_l_q));

  // Advance the grammar by one byte
  always_comb begin
    len_d        = len_q;
    phase_d      = phase_q;
    invalid_d    = invalid_q;
    r_neg_d      = r_neg_q;
    r_mag_d      = r_mag_q;
    l_neg_d      = l_neg_q;
    l_mag_d      = l_mag_q;
    last_valid_d = last_valid_q;
    last_r_d     = last_r_q;
    last_l_d     = last_l_q;

    if (s1_fire) begin
      if (is_collect && !is_eol && (len_q < LenLast)) begin
        len_d = len_q + LenW'(1);
        if (!invalid_q) begin
          unique case (phase_q)
            splcp_pkg::PH_R_START, splcp_pkg::PH_R_WS: begin
              if (is_sl && (phase_q == splcp_pkg::PH_R_START)) begin
                phase_d = splcp_pkg::PH_L_START;
              end else if (is_ws) begin
                phase_d = splcp_pkg::PH_R_WS;
              end else if (is_sgn) begin
                r_neg_d = is_minus;
                phase_d = splcp_pkg::PH_R_SIGN;
              end else if (is_dig) begin
                r_mag_d = r_add;
                phase_d = splcp_pkg::PH_R_DIG;
              end else begin
                invalid_d = 1'b1;
              end
            end
            splcp_pkg::PH_R_SIGN: begin
              if (is_dig) begin
                r_mag_d = r_add;
                phase_d = splcp_pkg::PH_R_DIG;
              end else begin
                invalid_d = 1'b1;
              end
            end
            splcp_pkg::PH_R_DIG: begin
              if (is_dig) begin
                r_mag_d = r_add;
              end else if (is_sl) begin
                phase_d = splcp_pkg::PH_L_START;
              end else begin
                invalid_d = 1'b1;
              end
            end
            splcp_pkg::PH_L_START: begin
              if (is_ws) begin
                phase_d = splcp_pkg::PH_L_START;
              end else if (is_sgn) begin
                l_neg_d = is_minus;
                phase_d = splcp_pkg::PH_L_SIGN;
              end else if (is_dig) begin
                l_mag_d = l_add;
                phase_d = splcp_pkg::PH_L_DIG;
              end else begin
                invalid_d = 1'b1;
              end
            end
            splcp_pkg::PH_L_SIGN: begin
              if (is_dig) begin
                l_mag_d = l_add;
                phase_d = splcp_pkg::PH_L_DIG;
              end else begin
                invalid_d = 1'b1;
              end
            end
            splcp_pkg::PH_L_DIG: begin
              if (is_dig) begin
                l_mag_d = l_add;
              end else if (is_ws) begin
                phase_d = splcp_pkg::PH_L_TAIL;
              end else begin
                invalid_d = 1'b1;
              end
            end
            splcp_pkg::PH_L_TAIL: begin
              if (!is_ws) begin
                invalid_d = 1'b1;
              end
            end
            default: begin
              invalid_d = 1'b1;
            end
          endcase
        end
      end else begin
        // drop the line: end of line, foreign byte or overflow
        len_d     = '0;
        phase_d   = splcp_pkg::PH_R_START;
        invalid_d = 1'b0;
        r_neg_d   = 1'b0;
        r_mag_d   = '0;
        l_neg_d   = 1'b0;
        l_mag_d   = '0;
      end

      if (emit) begin
        last_valid_d = 1'b1;
        last_r_d     = r_pat;
        last_l_d     = l_pat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q        <= '0;
      phase_q      <= splcp_pkg::PH_R_START;
      invalid_q    <= 1'b0;
      r_neg_q      <= 1'b0;
      r_mag_q      <= '0;
      l_neg_q      <= 1'b0;
      l_mag_q      <= '0;
      last_valid_q <= 1'b0;
      last_r_q     <= '0;
      last_l_q     <= '0;
    end else begin
      len_q        <= len_d;
      phase_q      <= phase_d;
      invalid_q    <= invalid_d;
      r_neg_q      <= r_neg_d;
      r_mag_q      <= r_mag_d;
      l_neg_q      <= l_neg_d;
      l_mag_q      <= l_mag_d;
      last_valid_q <= last_valid_d;
      last_r_q     <= last_r_d;
      last_l_q     <= last_l_d;
    end
  end

  // Result register
  logic [8:0] out_r_q, out_l_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_r_q <= r_pat;
      out_l_q <= l_pat;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign right_drive_o = out_r_q;
  assign left_drive_o  = out_l_q;

  // Checks
  `ASSERT_PROP(a_out_matches_last,
    !out_valid_q || (last_valid_q && (out_r_q == last_r_q) && (out_l_q == last_l_q)),
    "pending result differs from last sent pair")
  `ASSERT_PROP(a_empty_line_clean,
    (len_q != '0) || ((phase_q == splcp_pkg::PH_R_START) && !invalid_q),
    "empty line carries parser state")
  `ASSERT_NEXT(a_byte_held, s1_valid_q && !s1_adv,
    s1_valid_q && $stable(s1_byte_q), "held byte lost while result stalled")
  `ASSERT_NEXT(a_no_overwrite, out_valid_q && out_stall_i,
    out_valid_q && $stable(out_r_q) && $stable(out_l_q), "stalled result overwritten")

endmodule

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb: testbench of signed_pair_line_command_parser
// Feeds text lines byte by byte through the valid/stall input channel. A
// directed table of lines covers the extremes and the grammar corner cases.
// Random lines follow, mostly well formed with some broken, noisy or overlong
// ones, under several clamp limits. A line parser kept alongside the block
// predicts pairs of untyped lines. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_CHARS    = 32;
  localparam int PHASE_BYTES   = 250;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;

  typedef struct {
    logic signed [8:0] right;
    logic signed [8:0] left;
  } drive_pair_t;

  typedef struct {
    string text;
    bit    typed;
    bit    has;
    int    right;
    int    left;
  } stim_row_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [7:0]        cfg_data_i  = 8'd0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [7:0]        rx_byte_i   = 8'd0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic signed [8:0] right_drive_o;
  logic signed [8:0] left_drive_o;

  // Expected drive pairs, oldest first
  drive_pair_t expected_pairs[$];
  int          mismatches = 0;

  // Line parser state
  logic [7:0]        pwm_limit_q;
  int                line_len;
  splcp_pkg::phase_t phase;
  bit                bad;
  bit                r_neg;
  logic [8:0]        r_mag;
  bit                l_neg;
  logic [8:0]        l_mag;
  bit                sent_valid;
  logic [8:0]        sent_r;
  logic [8:0]        sent_l;

  // Line under construction and the last well formed one
  logic [7:0] line_buf[$];
  logic [7:0] prev_line[$];

  stim_row_t directed_rows[16];

  signed_pair_line_command_parser #(
    .LINE_BUFFER_SIZE(LINE_CHARS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .right_drive_o(right_drive_o),
    .left_drive_o (left_drive_o)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop if the run hangs
  initial begin
    #8_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Append a digit, saturating the magnitude
  function automatic logic [8:0] add_digit(input logic [8:0] mag, input logic [7:0] c);
    int v;
    v = int'(mag) * 10 + (int'(c) - int'(splcp_pkg::CH_ZERO));
    return (v > int'(splcp_pkg::MAG_MAX)) ? splcp_pkg::MAG_MAX : v[8:0];
  endfunction

  // Clamp a signed magnitude to the limit, as a 9 bit pattern
  function automatic logic [8:0] clamp_drive(input bit neg, input logic [8:0] mag);
    logic [8:0] m;
    m = (mag > {1'b0, pwm_limit_q}) ? {1'b0, pwm_limit_q} : mag;
    return neg ? (~m + 9'd1) : m;
  endfunction

  // Drop the line collected so far
  task automatic clear_line();
    line_len = 0;
    phase    = splcp_pkg::PH_R_START;
    bad      = 1'b0;
    r_neg    = 1'b0;
    r_mag    = '0;
    l_neg    = 1'b0;
    l_mag    = '0;
  endtask

  // Advance the line parser by one accepted byte
  task automatic parse_byte(input logic [7:0] c, output bit emit, output drive_pair_t pair);
    bit         dig;
    bit         ws;
    bit         sgn;
    bit         sl;
    logic [8:0] r;
    logic [8:0] l;
    emit       = 1'b0;
    pair.right = '0;
    pair.left  = '0;
    dig = (c >= splcp_pkg::CH_ZERO) && (c <= splcp_pkg::CH_NINE);
    ws  = (c == splcp_pkg::CH_SPACE) || (c == splcp_pkg::CH_TAB);
    sgn = (c == splcp_pkg::CH_PLUS) || (c == splcp_pkg::CH_MINUS);
    sl  = (c == splcp_pkg::CH_SLASH);
    if (c == splcp_pkg::CH_CR || c == splcp_pkg::CH_LF) begin
      // end of line: emit only a complete pair that differs from the last one
      if (line_len > 0 && !bad &&
          (phase == splcp_pkg::PH_L_START || phase == splcp_pkg::PH_L_DIG ||
           phase == splcp_pkg::PH_L_TAIL)) begin
        r = clamp_drive(r_neg, r_mag);
        l = clamp_drive(l_neg, l_mag);
        if (!sent_valid || r != sent_r || l != sent_l) begin
          sent_valid = 1'b1;
          sent_r     = r;
          sent_l     = l;
          emit       = 1'b1;
          pair.right = r;
          pair.left  = l;
        end
      end
      clear_line();
    end else if (dig || ws || sgn || sl) begin
      if (line_len < LINE_CHARS - 1) begin
        line_len++;
        if (!bad) begin
          case (phase)
            splcp_pkg::PH_R_START, splcp_pkg::PH_R_WS: begin
              if (sl && phase == splcp_pkg::PH_R_START) phase = splcp_pkg::PH_L_START;
              else if (ws) phase = splcp_pkg::PH_R_WS;
              else if (sgn) begin
                r_neg = (c == splcp_pkg::CH_MINUS);
                phase = splcp_pkg::PH_R_SIGN;
              end else if (dig) begin
                r_mag = add_digit(r_mag, c);
                phase = splcp_pkg::PH_R_DIG;
              end else bad = 1'b1;
            end
            splcp_pkg::PH_R_SIGN: begin
              if (dig) begin
                r_mag = add_digit(r_mag, c);
                phase = splcp_pkg::PH_R_DIG;
              end else bad = 1'b1;
            end
            splcp_pkg::PH_R_DIG: begin
              if (dig) r_mag = add_digit(r_mag, c);
              else if (sl) phase = splcp_pkg::PH_L_START;
              else bad = 1'b1;
            end
            splcp_pkg::PH_L_START: begin
              if (sgn) begin
                l_neg = (c == splcp_pkg::CH_MINUS);
                phase = splcp_pkg::PH_L_SIGN;
              end else if (dig) begin
                l_mag = add_digit(l_mag, c);
                phase = splcp_pkg::PH_L_DIG;
              end else if (!ws) bad = 1'b1;
            end
            splcp_pkg::PH_L_SIGN: begin
              if (dig) begin
                l_mag = add_digit(l_mag, c);
                phase = splcp_pkg::PH_L_DIG;
              end else bad = 1'b1;
            end
            splcp_pkg::PH_L_DIG: begin
              if (dig) l_mag = add_digit(l_mag, c);
              else if (ws) phase = splcp_pkg::PH_L_TAIL;
              else bad = 1'b1;
            end
            splcp_pkg::PH_L_TAIL: begin
              if (!ws) bad = 1'b1;
            end
            default: bad = 1'b1;
          endcase
        end
      end else begin
        // line too long: drop the byte and the line
        clear_line();
      end
    end else begin
      clear_line();
    end
  endtask

  // Idle length before a byte beat: mostly none, a few long
  function automatic int beat_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Present one byte beat, hold it until accepted, then predict
  task automatic send_byte(input logic [7:0] b, input int gap, output bit emit,
                           output drive_pair_t pair);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    parse_byte(b, emit, pair);
  endtask

  // Quiesce, then write the clamp limit
  task automatic write_limit(input logic [7:0] v);
    in_valid_i <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    pwm_limit_q = v;
  endtask

  function automatic int digit_count();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return $urandom_range(1, 3);
    if (r < 17) return 4;
    return $urandom_range(5, 8);
  endfunction

  task automatic put_digits(input int n);
    repeat (n) line_buf.push_back(splcp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic put_blanks(input int n);
    repeat (n) line_buf.push_back($urandom_range(0, 1) ? splcp_pkg::CH_SPACE
                                                       : splcp_pkg::CH_TAB);
  endtask

  task automatic put_sign();
    int s;
    s = $urandom_range(0, 2);
    if (s == 1) line_buf.push_back(splcp_pkg::CH_PLUS);
    else if (s == 2) line_buf.push_back(splcp_pkg::CH_MINUS);
  endtask

  task automatic put_end();
    line_buf.push_back($urandom_range(0, 1) ? splcp_pkg::CH_CR : splcp_pkg::CH_LF);
    if ($urandom_range(0, 7) == 0) line_buf.push_back(splcp_pkg::CH_LF);
  endtask

  // Well formed right/left text with random content, no terminator
  task automatic put_pair_body();
    if ($urandom_range(0, 7) != 0) begin
      if ($urandom_range(0, 3) == 0) put_blanks($urandom_range(1, 2));
      put_sign();
      put_digits(digit_count());
    end
    line_buf.push_back(splcp_pkg::CH_SLASH);
    if ($urandom_range(0, 3) == 0) put_blanks($urandom_range(1, 2));
    if ($urandom_range(0, 7) != 0) begin
      put_sign();
      put_digits(digit_count());
      if ($urandom_range(0, 3) == 0) put_blanks($urandom_range(1, 2));
    end
  endtask

  // Check each accepted result beat against the oldest expectation
  always @(posedge clk_i) begin : check_result
    drive_pair_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pairs.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: unexpected pair %0d/%0d", $realtime, right_drive_o, left_drive_o);
        mismatches++;
      end else begin
        want = expected_pairs.pop_front();
        if (right_drive_o !== want.right || left_drive_o !== want.left) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: pair mismatch, got %0d/%0d, want %0d/%0d", $realtime,
                     right_drive_o, left_drive_o, want.right, want.left);
          mismatches++;
        end
      end
    end
  end

  // Result stall: quiet, light and heavy stretches, now and then a long block
  initial begin : result_stall
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 9);
      span = $urandom_range(10, 120);
      if (mode == 0) begin
        @(posedge clk_i);
        out_stall_i <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        repeat (span) begin
          @(posedge clk_i);
          if (mode < 4) out_stall_i <= 1'b0;
          else if (mode < 8) out_stall_i <= ($urandom_range(0, 3) == 0);
          else out_stall_i <= ($urandom_range(0, 9) < 7);
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    bit          emit;
    bit          calm;
    drive_pair_t pair;
    int          kind;
    int          idx;
    int          phase_bytes;
    logic [7:0]  ch;
    logic [7:0]  limit_plan[6];

    directed_rows = '{
      '{"/\n",                 1'b1, 1'b1, 0,   0},
      '{"255/-255\015",        1'b1, 1'b1, 255, -255},
      '{"99999/-99999\n",      1'b1, 1'b0, 0,   0},
      '{"-0/5\n",              1'b1, 1'b1, 0,   5},
      '{"\n",                  1'b1, 1'b0, 0,   0},
      '{"12/\n",               1'b0, 1'b0, 0,   0},
      '{"  +7/  -8 \t\n",      1'b0, 1'b0, 0,   0},
      '{" 7 /8\n",             1'b0, 1'b0, 0,   0},
      '{"5/6 7\n",             1'b0, 1'b0, 0,   0},
      '{"12x/3\n",             1'b0, 1'b0, 0,   0},
      '{"+/1\n",               1'b0, 1'b0, 0,   0},
      '{"5\n",                 1'b0, 1'b0, 0,   0},
      '{"1/2/3\n",             1'b0, 1'b0, 0,   0},
      '{"-512/600\n",          1'b0, 1'b0, 0,   0},
      '{"1/222222222222222222222222222222\n", 1'b0, 1'b0, 0, 0},
      '{"0/0\015",             1'b0, 1'b0, 0,   0}
    };

    // Parser state after reset
    pwm_limit_q = splcp_pkg::PWM_LIMIT_RST;
    clear_line();
    sent_valid = 1'b0;
    sent_r     = '0;
    sent_l     = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines at the reset limit
    foreach (directed_rows[i]) begin
      for (int j = 0; j < directed_rows[i].text.len(); j++) begin
        send_byte(directed_rows[i].text[j], beat_gap(), emit, pair);
        if (directed_rows[i].typed) begin
          if (j == directed_rows[i].text.len() - 1 && directed_rows[i].has) begin
            pair.right = 9'(directed_rows[i].right);
            pair.left  = 9'(directed_rows[i].left);
            expected_pairs.push_back(pair);
          end
        end else if (emit) begin
          expected_pairs.push_back(pair);
        end
      end
    end

    // Random lines under a sequence of clamp limits
    limit_plan[0] = 8'd0;
    limit_plan[1] = 8'd1;
    limit_plan[2] = 8'd255;
    limit_plan[3] = 8'($urandom_range(2, 254));
    limit_plan[4] = 8'($urandom_range(1, 255));
    limit_plan[5] = 8'd128;

    for (int ph = 0; ph < 6; ph++) begin
      write_limit(limit_plan[ph]);
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        line_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind < 66 || (kind >= 95 && prev_line.size() == 0)) begin
          put_pair_body();
          put_end();
          prev_line = line_buf;
        end else if (kind < 78) begin
          // corrupt a well formed line at one spot
          put_pair_body();
          idx = $urandom_range(0, line_buf.size() - 1);
          case ($urandom_range(0, 5))
            0:       ch = splcp_pkg::CH_PLUS;
            1:       ch = splcp_pkg::CH_MINUS;
            2:       ch = splcp_pkg::CH_SLASH;
            3:       ch = splcp_pkg::CH_SPACE;
            4:       ch = splcp_pkg::CH_TAB;
            default: ch = splcp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
          endcase
          if ($urandom_range(0, 1)) line_buf[idx] = ch;
          else line_buf.insert(idx, ch);
          put_end();
        end else if (kind < 86) begin
          repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 91) begin
          put_digits(1);
          line_buf.push_back(splcp_pkg::CH_SLASH);
          put_digits($urandom_range(29, 40));
          put_end();
        end else if (kind < 95) begin
          put_end();
        end else begin
          line_buf = prev_line;
        end

        calm = ($urandom_range(0, 3) == 0);
        foreach (line_buf[i]) begin
          send_byte(line_buf[i], calm ? 0 : beat_gap(), emit, pair);
          if (emit) expected_pairs.push_back(pair);
        end
        phase_bytes += line_buf.size();
      end
    end

    // Drain and settle
    in_valid_i <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_pairs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/splcp_pkg.sv
rtl/signed_pair_line_command_parser.sv
tb/tb.sv
